>>> sv/sfb_pkg.sv
package sfb_pkg;

  localparam int DATA_BYTES   = 54;
  localparam int HDR_LEN      = 10;
  localparam int POS_W        = $clog2(DATA_BYTES + 1);
  localparam int HIDX_W       = $clog2(HDR_LEN);
  localparam int LFSR_W       = 15;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h0401;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CMDQ_DEPTH   = 2;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROTOCOL = 3'd0,
    REG_SOURCE   = 3'd1,
    REG_DEST     = 3'd2,
    REG_MSG_TYPE = 3'd3,
    REG_LENGTH   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_FIRST,
    BK_HDR,
    BK_DATA,
    BK_PAD
  } bk_state_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_done;
    logic       run_last;
  } out_word_t;

  // Classified work item handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] sample;
    logic       hdr;
    logic       pad;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  protocol_code;
    logic [15:0] source_address;
    logic [15:0] destination_address;
    logic [7:0]  message_type;
    logic [15:0] length_word;
    logic [15:0] checksum;
  } cfg_t;

  function automatic logic [7:0] hdr_byte(input logic [HIDX_W-1:0] idx, input cfg_t c);
    logic [7:0] b;
    case (idx)
      4'd0:    b = c.protocol_code;
      4'd1:    b = c.source_address[7:0];
      4'd2:    b = c.source_address[15:8];
      4'd3:    b = c.destination_address[7:0];
      4'd4:    b = c.destination_address[15:8];
      4'd5:    b = c.message_type;
      4'd6:    b = c.length_word[7:0];
      4'd7:    b = c.length_word[15:8];
      4'd8:    b = c.checksum[7:0];
      4'd9:    b = c.checksum[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/sfb_front.sv
module sfb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  sfb_pkg::in_word_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output sfb_pkg::cmd_t    q_cmd
);
  import sfb_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_inc;
  logic             fills;

  assign q_push  = in_push && !q_full;
  assign pos_inc = pos_r + POS_W'(1);
  assign fills   = (pos_inc == POS_W'(DATA_BYTES));

  // Tag each word: header first on a fresh frame, padding after an end marker
  // that leaves the frame open.
  always_comb begin
    q_cmd.sample = in_data.sample;
    q_cmd.hdr    = (pos_r == '0);
    q_cmd.pad    = in_data.end_of_stream && !fills;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (fills || in_data.end_of_stream) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> sv/sfb_cmd_fifo.sv
module sfb_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output sfb_pkg::cmd_t head
);
  import sfb_pkg::*;

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + CMDQ_PTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + CMDQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CMDQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CNT_W'(CMDQ_DEPTH)) else $error("command queue overfilled");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("command popped from empty queue");
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> valid) else $error("pushed command went missing");
`endif

endmodule

>>> sv/sfb_back.sv
module sfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  sfb_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  sfb_pkg::cfg_t      cfg,
  output logic               out_empty,
  input  logic               out_pop,
  output sfb_pkg::out_word_t out_data
);
  import sfb_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;

  out_word_t  obuf_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       obuf_full, opush, opop;

  logic       prod, emit_data, frame_end, item_end, fb, hdr_last;
  logic [7:0] data_in;
  out_word_t  word;

  assign obuf_full = (ocnt_r == 2'd2);
  assign prod      = cmd_valid && !obuf_full;
  assign emit_data = (state_r == BK_FIRST && !cmd.hdr) || state_r == BK_DATA ||
                     state_r == BK_PAD;
  assign data_in   = (state_r == BK_PAD) ? 8'h00 : cmd.sample;
  assign fb        = lfsr_r[0] ^ lfsr_r[1];
  assign pos_inc   = pos_r + POS_W'(1);
  assign frame_end = emit_data && (pos_inc == POS_W'(DATA_BYTES));
  assign item_end  = emit_data && (frame_end || (state_r != BK_PAD && !cmd.pad));
  assign hdr_last  = (hidx_r == HIDX_W'(HDR_LEN - 1));

  always_comb begin
    state_nxt = state_r;
    if (prod) begin
      case (state_r)
        BK_FIRST: begin
          if (cmd.hdr) begin
            state_nxt = BK_HDR;
          end else if (!item_end) begin
            state_nxt = BK_PAD;
          end
        end
        BK_HDR:  state_nxt = hdr_last ? BK_DATA : BK_HDR;
        BK_DATA: state_nxt = item_end ? BK_FIRST : BK_PAD;
        BK_PAD:  state_nxt = item_end ? BK_FIRST : BK_PAD;
        default: state_nxt = BK_FIRST;
      endcase
    end
  end

  always_comb begin
    word.frame_done = frame_end;
    word.run_last   = item_end;
    if (emit_data) begin
      word.frame_byte = {data_in[7:1], data_in[0] ^ fb};
    end else begin
      word.frame_byte = hdr_byte((state_r == BK_HDR) ? hidx_r : '0, cfg);
    end
    cmd_pop  = prod && item_end;
    hidx_nxt = hidx_r;
    pos_nxt  = pos_r;
    lfsr_nxt = lfsr_r;
    if (prod) begin
      if (state_r == BK_FIRST && cmd.hdr) begin
        hidx_nxt = HIDX_W'(1);
      end else if (state_r == BK_HDR) begin
        hidx_nxt = hdr_last ? '0 : hidx_r + HIDX_W'(1);
      end
      if (emit_data) begin
        if (frame_end) begin
          pos_nxt  = '0;
          lfsr_nxt = LFSR_SEED;
        end else begin
          pos_nxt  = pos_inc;
          lfsr_nxt = {fb, lfsr_r[LFSR_W-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_FIRST;
      hidx_r  <= '0;
      pos_r   <= '0;
      lfsr_r  <= LFSR_SEED;
    end else begin
      state_r <= state_nxt;
      hidx_r  <= hidx_nxt;
      pos_r   <= pos_nxt;
      lfsr_r  <= lfsr_nxt;
    end
  end

  // Two-entry output buffer
  assign opush     = prod;
  assign opop      = out_pop && !out_empty;
  assign out_empty = (ocnt_r == 2'd0);
  assign out_data  = obuf_r[orp_r];

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (opush && !opop) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (opop && !opush) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      owp_r  <= owp_r ^ opush;
      orp_r  <= orp_r ^ opop;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf_r[owp_r] <= word;
    end
  end

`ifndef SYNTHESIS
  a_obuf_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'd2) else $error("output buffer overfilled");
  a_frame_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    (prod && frame_end) |=> (pos_r == '0 && lfsr_r == LFSR_SEED))
    else $error("frame end did not reseed");
  a_hidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_HDR) |-> (hidx_r != '0 && hidx_r < HIDX_W'(HDR_LEN)))
    else $error("header index out of range");
`endif

endmodule

>>> sv/scrambled_frame_builder.sv
// Frame builder with PRBS15 scrambling. Each word pushed on the input carries
// one sample byte; the block emits 64-byte frames made of a 10-byte header
// (protocol code, source, destination, message type, length, checksum, all
// little-endian, checksum the one's complement of the low 16 bits of the field
// sum) followed by 54 data bytes whose LSB is XORed with a 15-bit LFSR bit
// reseeded to 0x0401 at every frame. A sample that ends the stream closes the
// frame with scrambled zero bytes. The back-end sequencer emits one byte per
// clock while a command waits and the output buffer has room; a sample in mid
// frame yields one data byte, the first of a frame the 10 header bytes plus
// its data byte, and an end-of-stream sample adds up to 53 pad bytes. Samples
// wait in the command queue, their bytes are registered in the output buffer;
// a two-word command queue and a two-word output buffer let input and output
// stall independently. Write the registers only while idle.
module scrambled_frame_builder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  sfb_pkg::in_word_t           in_data,
  output logic                        in_full,
  output logic                        out_empty,
  input  logic                        out_pop,
  output sfb_pkg::out_word_t          out_data,
  input  logic                        cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfb_pkg::CFG_W-1:0]   cfg_data
);
  import sfb_pkg::*;

  logic [7:0]  protocol_r;
  logic [15:0] source_r;
  logic [15:0] dest_r;
  logic [7:0]  msg_type_r;
  logic [15:0] length_r;
  logic [17:0] field_sum;
  cfg_t        cfg;

  logic q_push, q_full, q_valid, q_pop;
  cmd_t q_cmd, q_head;

  // Hold the header fields; ignore writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_r <= 8'd1;
      source_r   <= 16'd4097;
      dest_r     <= 16'd8193;
      msg_type_r <= 8'd1;
      length_r   <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROTOCOL: protocol_r <= cfg_data[7:0];
        REG_SOURCE:   source_r   <= cfg_data;
        REG_DEST:     dest_r     <= cfg_data;
        REG_MSG_TYPE: msg_type_r <= cfg_data[7:0];
        REG_LENGTH:   length_r   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Sum the fields wide, keep the low 16 bits, complement.
  assign field_sum = 18'(protocol_r) + 18'(source_r) + 18'(dest_r) +
                     18'(msg_type_r) + 18'(length_r);

  always_comb begin
    cfg.protocol_code       = protocol_r;
    cfg.source_address      = source_r;
    cfg.destination_address = dest_r;
    cfg.message_type        = msg_type_r;
    cfg.length_word         = length_r;
    cfg.checksum            = ~field_sum[15:0];
  end

  assign in_full = q_full;

  sfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  sfb_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  sfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .cfg       (cfg),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
